/* hdl/fresnel_dielectric_reflectance_macros.svh */
// Assertion macros used by the checker file of the Fresnel reflectance block.
`ifndef FRESNEL_DIELECTRIC_REFLECTANCE_MACROS_SVH
`define FRESNEL_DIELECTRIC_REFLECTANCE_MACROS_SVH

// Same-cycle implication, sampled on aclk, off during reset
`define FRDR_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("frdr assertion failed");

// Next-cycle implication, sampled on aclk, off during reset
`define FRDR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("frdr assertion failed");

`endif

/* hdl/frdr_pkg.sv */
// Types and constants of the Fresnel dielectric reflectance pipeline.
`timescale 1ns / 1ps
package frdr_pkg;

    typedef struct packed {
        logic signed [15:0] cos_incident;
        logic [15:0]        eta_outer;
        logic [15:0]        eta_inner;
    } in_t;

    typedef struct packed {
        logic [15:0] reflectance;
        logic        total_internal;
    } out_t;

    // Per-item data carried alongside the divide and root chains
    typedef struct packed {
        logic        tir;
        logic [16:0] ci;
        logic [15:0] ei;
        logic [15:0] et;
    } side_t;

    localparam int DIV_STEPS   = 30;
    localparam int SQRT_STEPS  = 16;
    localparam int RATIO_STEPS = 31;

    localparam logic [30:0] ONE_Q30   = 31'h4000_0000;
    localparam logic [31:0] ONE_Q31   = 32'h8000_0000;
    localparam logic [15:0] ONE_Q15   = 16'h8000;
    localparam logic [64:0] ROUND_Q48 = 65'h0_0000_8000_0000_0000;

endpackage

/* hdl/fresnel_dielectric_reflectance.sv */
// Pipeline: input transfer reaches result valid through the 30-cell divide chain,
// the 16-cell square-root chain and the 31-cell ratio chains plus ten arithmetic stages.
// Throughput: one item per cycle; the whole pipeline holds while a result waits untaken.
// Reset: aresetn, synchronous active low, clears all valid bits; no other state.
`timescale 1ns / 1ps
module fresnel_dielectric_reflectance (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  frdr_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output frdr_pkg::out_t m_data
);

    localparam int SIDE_W = $bits(frdr_pkg::side_t);
    localparam int DN = frdr_pkg::DIV_STEPS;
    localparam int SN = frdr_pkg::SQRT_STEPS;
    localparam int RN = frdr_pkg::RATIO_STEPS;

    logic adv;
    logic s_xfer;

    // pipeline advances whenever the output register is free or being emptied
    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;
    assign s_xfer  = s_valid && adv;

    // ---------------- stage A: orientation swap, |cos| ----------------
    logic               a_valid_reg;
    frdr_pkg::side_t    a_side_reg;
    frdr_pkg::side_t    a_side_next;
    logic [16:0]        neg_cos;

    always_comb begin
        neg_cos = 17'd0 - {s_data.cos_incident[15], s_data.cos_incident};
        a_side_next.tir = 1'b0;
        if (!s_data.cos_incident[15] && (s_data.cos_incident != 16'sd0)) begin
            a_side_next.ci = {1'b0, s_data.cos_incident};
            a_side_next.ei = s_data.eta_outer;
            a_side_next.et = s_data.eta_inner;
        end else begin
            a_side_next.ci = neg_cos;
            a_side_next.ei = s_data.eta_inner;
            a_side_next.et = s_data.eta_outer;
        end
    end

    // ---------------- stage B: squares ----------------
    logic            b_valid_reg;
    frdr_pkg::side_t b_side_reg;
    logic [30:0]     b_ci2_reg;
    logic [31:0]     b_ei2_reg;
    logic [31:0]     b_et2_reg;

    // ---------------- stage C: sin^2 incident ----------------
    logic            c_valid_reg;
    frdr_pkg::side_t c_side_reg;
    logic [30:0]     c_s2i_reg;
    logic [31:0]     c_ei2_reg;
    logic [31:0]     c_et2_reg;

    // ---------------- stage D: eta_i^2 * sin^2 ----------------
    logic            d_valid_reg;
    frdr_pkg::side_t d_side_reg;
    logic [62:0]     d_lhs_reg;
    logic [31:0]     d_et2_reg;

    // ---------------- stage E: TIR test, divider load ----------------
    logic            e_valid_reg;
    frdr_pkg::side_t e_side_reg;
    frdr_pkg::side_t e_side_next;
    logic [31:0]     e_rem_reg;
    logic [29:0]     e_low_reg;
    logic [31:0]     e_div_reg;

    always_comb begin
        e_side_next     = d_side_reg;
        e_side_next.tir = (d_lhs_reg >= {1'b0, d_et2_reg, 30'd0});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
        end else if (adv) begin
            a_valid_reg <= s_xfer;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
            e_valid_reg <= d_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a_side_reg <= a_side_next;
            b_side_reg <= a_side_reg;
            b_ci2_reg  <= 31'(34'(a_side_reg.ci) * 34'(a_side_reg.ci));
            b_ei2_reg  <= 32'(a_side_reg.ei) * 32'(a_side_reg.ei);
            b_et2_reg  <= 32'(a_side_reg.et) * 32'(a_side_reg.et);
            c_side_reg <= b_side_reg;
            c_s2i_reg  <= frdr_pkg::ONE_Q30 - b_ci2_reg;
            c_ei2_reg  <= b_ei2_reg;
            c_et2_reg  <= b_et2_reg;
            d_side_reg <= c_side_reg;
            d_lhs_reg  <= 63'(c_ei2_reg) * 63'(c_s2i_reg);
            d_et2_reg  <= c_et2_reg;
            e_side_reg <= e_side_next;
            e_rem_reg  <= d_lhs_reg[61:30];
            e_low_reg  <= d_lhs_reg[29:0];
            e_div_reg  <= d_et2_reg;
        end
    end

    // ---------------- divide chain: sin^2 transmitted ----------------
    logic                  dv_valid [0:DN];
    logic [31:0]           dv_rem   [0:DN];
    logic [29:0]           dv_low   [0:DN];
    logic [31:0]           dv_div   [0:DN];
    logic [SIDE_W-1:0]     dv_side  [0:DN];

    assign dv_valid[0] = e_valid_reg;
    assign dv_rem[0]   = e_rem_reg;
    assign dv_low[0]   = e_low_reg;
    assign dv_div[0]   = e_div_reg;
    assign dv_side[0]  = e_side_reg;

    for (genvar k = 0; k < DN; k++) begin : g_div
        frdr_div_cell #(.W(32), .Q(30), .DW(32), .SW(SIDE_W)) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (adv),
            .in_valid (dv_valid[k]),
            .in_rem   (dv_rem[k]),
            .in_low   (dv_low[k]),
            .in_div   (dv_div[k]),
            .in_side  (dv_side[k]),
            .out_valid(dv_valid[k+1]),
            .out_rem  (dv_rem[k+1]),
            .out_low  (dv_low[k+1]),
            .out_div  (dv_div[k+1]),
            .out_side (dv_side[k+1])
        );
    end

    // ---------------- stage F: cos^2 transmitted radicand ----------------
    logic              f_valid_reg;
    logic [SIDE_W-1:0] f_side_reg;
    logic [31:0]       f_v_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
        end else if (adv) begin
            f_valid_reg <= dv_valid[DN];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            f_side_reg <= dv_side[DN];
            f_v_reg    <= 32'(frdr_pkg::ONE_Q30 - {1'b0, dv_low[DN]});
        end
    end

    // ---------------- square-root chain: cos transmitted ----------------
    logic              sq_valid [0:SN];
    logic [31:0]       sq_v     [0:SN];
    logic [31:0]       sq_res   [0:SN];
    logic [SIDE_W-1:0] sq_side  [0:SN];

    assign sq_valid[0] = f_valid_reg;
    assign sq_v[0]     = f_v_reg;
    assign sq_res[0]   = 32'd0;
    assign sq_side[0]  = f_side_reg;

    for (genvar k = 0; k < SN; k++) begin : g_sqrt
        frdr_sqrt_cell #(.W(32), .SHIFT(30 - 2 * k), .SW(SIDE_W)) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (adv),
            .in_valid (sq_valid[k]),
            .in_v     (sq_v[k]),
            .in_res   (sq_res[k]),
            .in_side  (sq_side[k]),
            .out_valid(sq_valid[k+1]),
            .out_v    (sq_v[k+1]),
            .out_res  (sq_res[k+1]),
            .out_side (sq_side[k+1])
        );
    end

    // ---------------- stage G: cross products ----------------
    frdr_pkg::side_t g_in_side;
    logic [15:0]     g_ct;
    logic            g_valid_reg;
    logic            g_tir_reg;
    logic [31:0]     g_ti_reg;
    logic [31:0]     g_it_reg;
    logic [31:0]     g_ii_reg;
    logic [31:0]     g_tt_reg;

    assign g_in_side = sq_side[SN];
    assign g_ct      = sq_res[SN][15:0];

    // ---------------- stage H: amplitude numerators and denominators ----------------
    logic [31:0] h_mag_p;
    logic [31:0] h_den_p;
    logic [31:0] h_mag_s;
    logic [31:0] h_den_s;
    logic        h_cap_p;
    logic        h_cap_s;
    logic        h_valid_reg;
    logic [1:0]  h_side_p_reg;
    logic        h_cap_s_reg;
    logic [31:0] h_rem_p_reg;
    logic [31:0] h_rem_s_reg;
    logic [31:0] h_den_p_reg;
    logic [31:0] h_den_s_reg;

    always_comb begin
        h_mag_p = (g_ti_reg >= g_it_reg) ? (g_ti_reg - g_it_reg) : (g_it_reg - g_ti_reg);
        h_den_p = g_ti_reg + g_it_reg;
        h_mag_s = (g_ii_reg >= g_tt_reg) ? (g_ii_reg - g_tt_reg) : (g_tt_reg - g_ii_reg);
        h_den_s = g_ii_reg + g_tt_reg;
        h_cap_p = (h_den_p == 32'd0) || (h_mag_p >= h_den_p);
        h_cap_s = (h_den_s == 32'd0) || (h_mag_s >= h_den_s);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            g_valid_reg <= 1'b0;
            h_valid_reg <= 1'b0;
        end else if (adv) begin
            g_valid_reg <= sq_valid[SN];
            h_valid_reg <= g_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            g_tir_reg    <= g_in_side.tir;
            g_ti_reg     <= 32'(g_in_side.et) * 32'(g_in_side.ci);
            g_it_reg     <= 32'(g_in_side.ei) * 32'(g_ct);
            g_ii_reg     <= 32'(g_in_side.ei) * 32'(g_in_side.ci);
            g_tt_reg     <= 32'(g_in_side.et) * 32'(g_ct);
            h_side_p_reg <= {g_tir_reg, h_cap_p};
            h_cap_s_reg  <= h_cap_s;
            h_rem_p_reg  <= h_cap_p ? 32'd0 : h_mag_p;
            h_rem_s_reg  <= h_cap_s ? 32'd0 : h_mag_s;
            h_den_p_reg  <= h_den_p;
            h_den_s_reg  <= h_den_s;
        end
    end

    // ---------------- ratio chains: parallel and perpendicular amplitudes ----------------
    logic        rp_valid [0:RN];
    logic [31:0] rp_rem   [0:RN];
    logic [30:0] rp_low   [0:RN];
    logic [31:0] rp_div   [0:RN];
    logic [1:0]  rp_side  [0:RN];
    logic        rs_valid [0:RN];
    logic [31:0] rs_rem   [0:RN];
    logic [30:0] rs_low   [0:RN];
    logic [31:0] rs_div   [0:RN];
    logic [0:0]  rs_side  [0:RN];

    assign rp_valid[0] = h_valid_reg;
    assign rp_rem[0]   = h_rem_p_reg;
    assign rp_low[0]   = 31'd0;
    assign rp_div[0]   = h_den_p_reg;
    assign rp_side[0]  = h_side_p_reg;
    assign rs_valid[0] = h_valid_reg;
    assign rs_rem[0]   = h_rem_s_reg;
    assign rs_low[0]   = 31'd0;
    assign rs_div[0]   = h_den_s_reg;
    assign rs_side[0]  = h_cap_s_reg;

    for (genvar k = 0; k < RN; k++) begin : g_ratio
        frdr_div_cell #(.W(32), .Q(31), .DW(32), .SW(2)) u_par (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (adv),
            .in_valid (rp_valid[k]),
            .in_rem   (rp_rem[k]),
            .in_low   (rp_low[k]),
            .in_div   (rp_div[k]),
            .in_side  (rp_side[k]),
            .out_valid(rp_valid[k+1]),
            .out_rem  (rp_rem[k+1]),
            .out_low  (rp_low[k+1]),
            .out_div  (rp_div[k+1]),
            .out_side (rp_side[k+1])
        );
        frdr_div_cell #(.W(32), .Q(31), .DW(32), .SW(1)) u_perp (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (adv),
            .in_valid (rs_valid[k]),
            .in_rem   (rs_rem[k]),
            .in_low   (rs_low[k]),
            .in_div   (rs_div[k]),
            .in_side  (rs_side[k]),
            .out_valid(rs_valid[k+1]),
            .out_rem  (rs_rem[k+1]),
            .out_low  (rs_low[k+1]),
            .out_div  (rs_div[k+1]),
            .out_side (rs_side[k+1])
        );
    end

    // ---------------- stage J: squared amplitudes ----------------
    logic [31:0] j_rpar;
    logic [31:0] j_rperp;
    logic        j_valid_reg;
    logic        j_tir_reg;
    logic [63:0] j_sq_p_reg;
    logic [63:0] j_sq_s_reg;

    assign j_rpar  = rp_side[RN][0] ? frdr_pkg::ONE_Q31 : {1'b0, rp_low[RN]};
    assign j_rperp = rs_side[RN][0] ? frdr_pkg::ONE_Q31 : {1'b0, rs_low[RN]};

    // ---------------- output register: mean, rounding, saturation ----------------
    logic [64:0]    o_sum;
    logic [16:0]    o_round;
    frdr_pkg::out_t o_next;
    logic           m_valid_reg;
    frdr_pkg::out_t m_data_reg;

    always_comb begin
        o_sum   = 65'(j_sq_p_reg) + 65'(j_sq_s_reg) + frdr_pkg::ROUND_Q48;
        o_round = o_sum[64:48];
        o_next.total_internal = j_tir_reg;
        if (j_tir_reg || (o_round >= 17'(frdr_pkg::ONE_Q15))) begin
            o_next.reflectance = frdr_pkg::ONE_Q15;
        end else begin
            o_next.reflectance = o_round[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            j_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            j_valid_reg <= rp_valid[RN] && rs_valid[RN];
            m_valid_reg <= j_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            j_tir_reg  <= rp_side[RN][1];
            j_sq_p_reg <= 64'(j_rpar) * 64'(j_rpar);
            j_sq_s_reg <= 64'(j_rperp) * 64'(j_rperp);
            m_data_reg <= o_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // unused chain tails
    logic unused_tails;
    assign unused_tails = ^{dv_rem[DN], dv_div[DN], sq_v[SN], sq_res[SN][31:16],
                            rp_rem[RN], rp_div[RN], rs_rem[RN], rs_div[RN]};

endmodule

/* hdl/frdr_div_cell.sv */
// One restoring long-division step, registered, passing its partial result on.
`timescale 1ns / 1ps
module frdr_div_cell #(
    parameter int W  = 32,
    parameter int Q  = 30,
    parameter int DW = 32,
    parameter int SW = 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  logic [W-1:0]  in_rem,
    input  logic [Q-1:0]  in_low,
    input  logic [DW-1:0] in_div,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    output logic [W-1:0]  out_rem,
    output logic [Q-1:0]  out_low,
    output logic [DW-1:0] out_div,
    output logic [SW-1:0] out_side
);

    logic [W:0]    trial;
    logic [W:0]    div_ext;
    logic [W:0]    diff;
    logic          take;
    logic [W-1:0]  rem_next;
    logic [Q-1:0]  low_next;
    logic          valid_reg;
    logic [W-1:0]  rem_reg;
    logic [Q-1:0]  low_reg;
    logic [DW-1:0] div_reg;
    logic [SW-1:0] side_reg;

    // shift in the next dividend bit, subtract when it fits
    assign trial    = {in_rem, in_low[Q-1]};
    assign div_ext  = (W+1)'(in_div);
    assign take     = (trial >= div_ext);
    assign diff     = trial - div_ext;
    assign rem_next = take ? diff[W-1:0] : trial[W-1:0];
    assign low_next = {in_low[Q-2:0], take};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg  <= rem_next;
            low_reg  <= low_next;
            div_reg  <= in_div;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_low   = low_reg;
    assign out_div   = div_reg;
    assign out_side  = side_reg;

endmodule

/* hdl/frdr_sqrt_cell.sv */
// One digit step of the integer square root, registered, passing its state on.
`timescale 1ns / 1ps
module frdr_sqrt_cell #(
    parameter int W     = 32,
    parameter int SHIFT = 30,
    parameter int SW    = 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  logic [W-1:0]  in_v,
    input  logic [W-1:0]  in_res,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    output logic [W-1:0]  out_v,
    output logic [W-1:0]  out_res,
    output logic [SW-1:0] out_side
);

    localparam logic [W-1:0] BIT = W'(1) << SHIFT;

    logic [W-1:0]  trial;
    logic          take;
    logic [W-1:0]  v_next;
    logic [W-1:0]  res_next;
    logic          valid_reg;
    logic [W-1:0]  v_reg;
    logic [W-1:0]  res_reg;
    logic [SW-1:0] side_reg;

    // try res + bit against what is left of the radicand
    assign trial    = in_res + BIT;
    assign take     = (in_v >= trial);
    assign v_next   = take ? (in_v - trial) : in_v;
    assign res_next = take ? ((in_res >> 1) + BIT) : (in_res >> 1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            v_reg    <= v_next;
            res_reg  <= res_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_v     = v_reg;
    assign out_res   = res_reg;
    assign out_side  = side_reg;

endmodule

/* hdl/frdr_checker.sv */
// Port-level checker for the Fresnel reflectance block, bound to the top level.
`timescale 1ns / 1ps
`include "fresnel_dielectric_reflectance_macros.svh"
module frdr_checker (
    input logic           aclk,
    input logic           aresetn,
    input logic           s_valid,
    input logic           s_ready,
    input frdr_pkg::in_t  s_data,
    input logic           m_valid,
    input logic           m_ready,
    input frdr_pkg::out_t m_data
);

    // a stalled result holds
    `FRDR_ASSERT_NEXT(a_m_hold, m_valid && !m_ready, m_valid && $stable(m_data))

    // total internal reflection always reads as full reflectance
    `FRDR_ASSERT_IMPL(a_tir_full, m_valid && m_data.total_internal, m_data.reflectance == 16'h8000)

    // reflectance never exceeds 1.0
    `FRDR_ASSERT_IMPL(a_sat, m_valid, m_data.reflectance <= 16'h8000)

    // input side is open whenever the output register is free
    `FRDR_ASSERT_IMPL(a_ready_free, !m_valid || m_ready, s_ready)

    logic unused_in;
    assign unused_in = s_valid ^ (^s_data);

endmodule

bind fresnel_dielectric_reflectance frdr_checker u_frdr_checker (.*);
